/* rtl/mra_pkg.sv */
// Package for the memory request arbiter.
// Holds the payload structs, queue entry, controller state and command types.
// No dependencies.
`default_nettype none

package mra_pkg;

  // Field widths and codes
  localparam int unsigned TAG_BITS              = 16;
  localparam int unsigned SRC_W                 = 2;
  localparam int unsigned LIMIT_W               = 7;
  localparam int unsigned COUNT_OUT_W           = 7;
  localparam int unsigned WALKER_COUNT          = 3;
  localparam int unsigned PENDING_DEPTH_DEFAULT = 64;

  localparam logic [SRC_W-1:0]   SRC_CTRL    = 2'd3;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd16;

  // APB register map: one 32-bit register, word index taken from paddr[2]
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic        REG_LIMIT  = 1'b0;

  // Request kinds
  localparam logic REQ_ARB  = 1'b0;
  localparam logic REQ_RESP = 1'b1;

  typedef struct packed {
    logic                req_type;
    logic                ctrl_pending;
    logic                walker_a_pending;
    logic                walker_b_pending;
    logic                walker_c_pending;
    logic [TAG_BITS-1:0] walker_a_tag;
    logic [TAG_BITS-1:0] walker_b_tag;
    logic [TAG_BITS-1:0] walker_c_tag;
    logic                resp_failed;
  } in_item_t;

  typedef struct packed {
    logic                   grant_valid;
    logic [SRC_W-1:0]       grant_source;
    logic [TAG_BITS-1:0]    grant_tag;
    logic                   stalled;
    logic                   resp_valid;
    logic [SRC_W-1:0]       resp_source;
    logic [TAG_BITS-1:0]    resp_tag;
    logic                   resp_error;
    logic                   spurious_resp;
    logic [COUNT_OUT_W-1:0] in_flight;
  } out_item_t;

  typedef struct packed {
    logic [SRC_W-1:0]    source;
    logic [TAG_BITS-1:0] tag;
  } entry_t;

  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load_arb;
    logic load_spur;
    logic start_read;
    logic load_resp;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
    logic queue_empty;
  } status_t;

endpackage

`default_nettype wire

/* rtl/memory_request_arbiter.sv */
// Memory request arbiter, top level. Arbitration items and responses to an
// empty queue give their result in the cycle after transfer; one such item per
// cycle while the output is not stalled. A matched response passes through ST_RESP
// (registered read of the pending queue memory) and blocks input in that state. Reset
// clears pointers, count, rotate pointer and limit (16); the queue memory is not cleared.
// Depends on mra_pkg, mra_regs, mra_ctrl, mra_datapath.
`default_nettype none

module memory_request_arbiter #(
  parameter int unsigned PENDING_DEPTH = mra_pkg::PENDING_DEPTH_DEFAULT
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire mra_pkg::in_item_t              in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output mra_pkg::out_item_t                  out_data_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [mra_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [mra_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [mra_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready
);

  logic [mra_pkg::LIMIT_W-1:0] limit;
  mra_pkg::cmd_t               cmd;
  mra_pkg::status_t            status;

  mra_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limit_o (limit)
  );

  mra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (in_data_i.req_type),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  mra_datapath #(
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .limit_i     (limit),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

/* rtl/mra_regs.sv */
// APB-style configuration register for the memory request arbiter.
// Holds the outstanding limit. Depends on mra_pkg.
`default_nettype none

module mra_regs (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [mra_pkg::APB_ADDR_W-1:0]      paddr,
  input  wire logic [mra_pkg::APB_DATA_W-1:0]      pwdata,
  output logic      [mra_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                     pready,
  output logic      [mra_pkg::LIMIT_W-1:0]         limit_o
);

  logic [mra_pkg::LIMIT_W-1:0] limit_q, limit_d;
  logic                        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready & (paddr[2] == mra_pkg::REG_LIMIT);

  always_comb begin
    limit_d = limit_q;
    if (wr_en) begin
      limit_d = pwdata[mra_pkg::LIMIT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= mra_pkg::LIMIT_RESET;
    end else begin
      limit_q <= limit_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == mra_pkg::REG_LIMIT) begin
      prdata = mra_pkg::APB_DATA_W'(limit_q);
    end
  end

  assign limit_o = limit_q;

endmodule

`default_nettype wire

/* rtl/mra_ctrl.sv */
// Controller for the memory request arbiter: accepts items and sequences
// the response path through the ST_RESP state. Depends on mra_pkg.
`default_nettype none

module mra_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             req_type_i,
  input  wire mra_pkg::status_t status_i,
  output logic                  in_stall_o,
  output mra_pkg::cmd_t         cmd_o
);

  mra_pkg::state_e state_q, state_d;
  logic            accept;

  assign accept = (state_q == mra_pkg::ST_IDLE) & in_valid_i & status_i.out_free;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mra_pkg::ST_IDLE: begin
        if (accept && req_type_i == mra_pkg::REQ_RESP && !status_i.queue_empty) begin
          state_d = mra_pkg::ST_RESP;
        end
      end
      mra_pkg::ST_RESP: begin
        state_d = mra_pkg::ST_IDLE;
      end
      default: begin
        state_d = mra_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      mra_pkg::ST_IDLE: begin
        in_stall_o       = !status_i.out_free;
        cmd_o.load_arb   = accept & (req_type_i == mra_pkg::REQ_ARB);
        cmd_o.load_spur  = accept & (req_type_i == mra_pkg::REQ_RESP) & status_i.queue_empty;
        cmd_o.start_read = accept & (req_type_i == mra_pkg::REQ_RESP) & !status_i.queue_empty;
      end
      mra_pkg::ST_RESP: begin
        // head entry is in the read register now
        cmd_o.load_resp = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mra_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/mra_datapath.sv */
// Datapath for the memory request arbiter: priority and round-robin pick,
// pending queue memory with pointers and count, and the output register.
// Depends on mra_pkg.
`default_nettype none

module mra_datapath #(
  parameter int unsigned PENDING_DEPTH = mra_pkg::PENDING_DEPTH_DEFAULT
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire mra_pkg::in_item_t             in_data_i,
  input  wire logic [mra_pkg::LIMIT_W-1:0]   limit_i,
  input  wire mra_pkg::cmd_t                 cmd_i,
  output mra_pkg::status_t                   status_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output mra_pkg::out_item_t                 out_data_o
);

  localparam int unsigned PTR_W = $clog2(PENDING_DEPTH);
  localparam int unsigned CNT_W = $clog2(PENDING_DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > mra_pkg::LIMIT_W) ? CNT_W : mra_pkg::LIMIT_W;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(PENDING_DEPTH - 1);
  localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(PENDING_DEPTH);

  // Pending queue storage, no reset
  mra_pkg::entry_t mem_q [PENDING_DEPTH];
  mra_pkg::entry_t rd_data_q;
  logic            err_q;

  logic [1:0]       rotate_q, rotate_d;
  logic [PTR_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0] count_q, count_d;

  mra_pkg::out_item_t out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic [2:0]                    walk;
  logic [mra_pkg::TAG_BITS-1:0]  tags [mra_pkg::WALKER_COUNT];
  logic                          any_req, at_limit, grant, push;
  logic [CMP_W-1:0]              limit_eff;
  logic                          found;
  logic [1:0]                    win_idx;
  logic [mra_pkg::TAG_BITS-1:0]  win_tag;
  logic [mra_pkg::SRC_W-1:0]     grant_src;
  logic [mra_pkg::TAG_BITS-1:0]  grant_tag;

  assign walk    = {in_data_i.walker_c_pending, in_data_i.walker_b_pending,
                    in_data_i.walker_a_pending};
  assign tags[0] = in_data_i.walker_a_tag;
  assign tags[1] = in_data_i.walker_b_tag;
  assign tags[2] = in_data_i.walker_c_tag;

  assign any_req   = in_data_i.ctrl_pending | (|walk);
  assign limit_eff = (CMP_W'(limit_i) > DEPTH_CMP) ? DEPTH_CMP : CMP_W'(limit_i);
  assign at_limit  = CMP_W'(count_q) >= limit_eff;
  assign grant     = any_req & !at_limit;
  assign push      = cmd_i.load_arb & grant;

  // Round-robin search from the rotate pointer
  always_comb begin
    logic [2:0] slot;
    found   = 1'b0;
    win_idx = '0;
    win_tag = '0;
    for (int k = 0; k < mra_pkg::WALKER_COUNT; k++) begin
      slot = {1'b0, rotate_q} + 3'(k);
      if (slot >= 3'(mra_pkg::WALKER_COUNT)) begin
        slot = slot - 3'(mra_pkg::WALKER_COUNT);
      end
      if (!found && walk[slot[1:0]]) begin
        found   = 1'b1;
        win_idx = slot[1:0];
        win_tag = tags[slot[1:0]];
      end
    end
  end

  assign grant_src = in_data_i.ctrl_pending ? mra_pkg::SRC_CTRL : win_idx;
  assign grant_tag = in_data_i.ctrl_pending ? '0 : win_tag;

  always_comb begin
    rotate_d = rotate_q;
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    if (push) begin
      tail_d  = (tail_q == LAST_SLOT) ? '0 : tail_q + PTR_W'(1);
      count_d = count_q + CNT_W'(1);
      if (!in_data_i.ctrl_pending && found) begin
        rotate_d = (win_idx == 2'd2) ? 2'd0 : win_idx + 2'd1;
      end
    end
    if (cmd_i.load_resp) begin
      head_d  = (head_q == LAST_SLOT) ? '0 : head_q + PTR_W'(1);
      count_d = count_q - CNT_W'(1);
    end
  end

  // Output register
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q & out_stall_i;
    if (cmd_i.load_arb) begin
      out_d              = '0;
      out_d.grant_valid  = grant;
      out_d.grant_source = grant ? grant_src : '0;
      out_d.grant_tag    = grant ? grant_tag : '0;
      out_d.stalled      = any_req & at_limit;
      out_d.in_flight    = mra_pkg::COUNT_OUT_W'(count_q + CNT_W'(grant));
      out_valid_d        = 1'b1;
    end
    if (cmd_i.load_spur) begin
      out_d               = '0;
      out_d.spurious_resp = 1'b1;
      out_d.in_flight     = mra_pkg::COUNT_OUT_W'(count_q);
      out_valid_d         = 1'b1;
    end
    if (cmd_i.load_resp) begin
      out_d             = '0;
      out_d.resp_valid  = 1'b1;
      out_d.resp_source = rd_data_q.source;
      out_d.resp_tag    = rd_data_q.tag;
      out_d.resp_error  = err_q;
      out_d.in_flight   = mra_pkg::COUNT_OUT_W'(count_q - CNT_W'(1));
      out_valid_d       = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotate_q    <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rotate_q    <= rotate_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers and queue memory
  always_ff @(posedge clk_i) begin
    out_q     <= out_d;
    rd_data_q <= mem_q[head_q];
    if (push) begin
      mem_q[tail_q] <= '{source: grant_src, tag: grant_tag};
    end
    if (cmd_i.start_read) begin
      err_q <= in_data_i.resp_failed;
    end
  end

  assign status_o.out_free    = !out_valid_q | !out_stall_i;
  assign status_o.queue_empty = (count_q == '0);

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
